// File: hw/rtl/rgbhsv_pkg.sv
package rgbhsv_pkg;

    localparam int CH_W          = 8;
    localparam int HUE_W         = 9;
    localparam int DIV_STEPS     = 8;
    localparam int STEPS_PER_STG = 2;
    localparam int NUM_DIV_STG   = DIV_STEPS / STEPS_PER_STG;

    localparam logic [HUE_W-1:0] HUE_GREEN_OFF = 9'd120;
    localparam logic [HUE_W-1:0] HUE_BLUE_OFF  = 9'd240;
    localparam logic [HUE_W-1:0] HUE_WRAP      = 9'd360;
    localparam logic [HUE_W-1:0] HUE_MAX       = 9'd359;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    // partial remainder, dividend bits still to shift in, quotient so far
    typedef struct packed {
        logic [CH_W-1:0] rem;
        logic [CH_W-1:0] low;
        logic [CH_W-1:0] quo;
    } div_t;

    typedef struct packed {
        logic [CH_W-1:0] val;
        logic [CH_W-1:0] delta;
        logic            grey;
        sector_t         sector;
        logic            neg;
        div_t            sat;
        div_t            hue;
    } stage_t;

    // one restoring division step, remainder stays below the divisor
    function automatic div_t div_step(input div_t s, input logic [CH_W-1:0] d);
        logic [CH_W:0] trial;
        div_t          r;
        trial = {s.rem, s.low[CH_W-1]};
        r.low = {s.low[CH_W-2:0], 1'b0};
        if (trial >= {1'b0, d})
        begin
            trial = trial - {1'b0, d};
            r.quo = {s.quo[CH_W-2:0], 1'b1};
        end
        else
        begin
            r.quo = {s.quo[CH_W-2:0], 1'b0};
        end
        r.rem = trial[CH_W-1:0];
        return r;
    endfunction

endpackage

// File: hw/rtl/rgb_to_hsv_pixel_core.sv
// channel | direction | handshake             | payload
// pix     | in        | pix_valid / pix_ready | red_in, green_in, blue_in
// hsv     | out       | hsv_valid / hsv_ready | hue_deg, sat_scaled, val_out
//
// one pixel per cycle sustained while hsv_ready stays high
// latency set by two long divisions (saturation and hue fraction), two
// quotient bits per stage over four stages, plus a front and an output stage
// reset clears the stage valid bits only
// each stage holds under backpressure and takes new data when it is empty or its contents move on,
// so bubbles close up and nothing is dropped or repeated
module rgb_to_hsv_pixel_core
    import rgbhsv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    output logic              pix_ready,
    input  logic [CH_W-1:0]   red_in,
    input  logic [CH_W-1:0]   green_in,
    input  logic [CH_W-1:0]   blue_in,
    output logic              hsv_valid,
    input  logic              hsv_ready,
    output logic [HUE_W-1:0]  hue_deg,
    output logic [CH_W-1:0]   sat_scaled,
    output logic [CH_W-1:0]   val_out
);

    localparam int LAST = NUM_DIV_STG + 1;

    logic [LAST:0]     v_reg;
    logic [LAST:0]     adv;
    stage_t            stg_reg  [0:NUM_DIV_STG];
    stage_t            stg_next [0:NUM_DIV_STG];
    logic [HUE_W-1:0]  hue_reg, hue_next;
    logic [CH_W-1:0]   sat_reg;
    logic [CH_W-1:0]   val_reg;

    // handshake chain
    always_comb
    begin
        adv[LAST] = !v_reg[LAST] || hsv_ready;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end

    assign pix_ready = adv[0];

    // front stage: max, min, sector and dividends
    always_comb
    begin
        logic [CH_W-1:0]   hi;
        logic [CH_W-1:0]   lo;
        logic [CH_W-1:0]   delta;
        logic [CH_W-1:0]   diff;
        logic [2*CH_W-1:0] sat_num;
        logic [2*CH_W-1:0] hue_num;
        sector_t           sector;
        logic              neg;

        hi = (red_in > green_in) ? red_in : green_in;
        hi = (hi > blue_in) ? hi : blue_in;
        lo = (red_in < green_in) ? red_in : green_in;
        lo = (lo < blue_in) ? lo : blue_in;
        delta = hi - lo;

        if (red_in >= hi)
        begin
            sector = SECT_RED;
            neg    = green_in < blue_in;
            diff   = neg ? blue_in - green_in : green_in - blue_in;
        end
        else if (green_in >= hi)
        begin
            sector = SECT_GREEN;
            neg    = blue_in < red_in;
            diff   = neg ? red_in - blue_in : blue_in - red_in;
        end
        else
        begin
            sector = SECT_BLUE;
            neg    = red_in < green_in;
            diff   = neg ? green_in - red_in : red_in - green_in;
        end

        // 255 * delta and 60 * diff by shift and subtract
        sat_num = {delta, {CH_W{1'b0}}} - {{CH_W{1'b0}}, delta};
        hue_num = {2'b00, diff, 6'b0} - {6'b0, diff, 2'b00};

        stg_next[0].val     = hi;
        stg_next[0].delta   = delta;
        stg_next[0].grey    = (delta == '0);
        stg_next[0].sector  = sector;
        stg_next[0].neg     = neg;
        stg_next[0].sat.rem = sat_num[2*CH_W-1:CH_W];
        stg_next[0].sat.low = sat_num[CH_W-1:0];
        stg_next[0].sat.quo = '0;
        stg_next[0].hue.rem = hue_num[2*CH_W-1:CH_W];
        stg_next[0].hue.low = hue_num[CH_W-1:0];
        stg_next[0].hue.quo = '0;
    end

    // division stages
    generate
        for (genvar k = 0; k < NUM_DIV_STG; k++)
        begin : g_div
            always_comb
            begin
                stage_t s;
                s = stg_reg[k];
                for (int j = 0; j < STEPS_PER_STG; j++)
                begin
                    s.sat = div_step(s.sat, s.val);
                    s.hue = div_step(s.hue, s.delta);
                end
                stg_next[k+1] = s;
            end
        end
    endgenerate

    // final hue from sector offset and fraction, rounded toward zero, clamped to HUE_MAX, zero for grey
    always_comb
    begin
        stage_t           s;
        logic [HUE_W-1:0] q;
        logic [HUE_W-1:0] up;
        logic [HUE_W-1:0] h;

        s  = stg_reg[NUM_DIV_STG];
        q  = {1'b0, s.hue.quo};
        up = q + {{(HUE_W-1){1'b0}}, (s.hue.rem != '0)};
        case (s.sector)
            SECT_RED:   h = s.neg ? HUE_WRAP - up : q;
            SECT_GREEN: h = s.neg ? HUE_GREEN_OFF - up : HUE_GREEN_OFF + q;
            default:    h = s.neg ? HUE_BLUE_OFF - up : HUE_BLUE_OFF + q;
        endcase
        if (h > HUE_MAX)
        begin
            h = HUE_MAX;
        end
        hue_next = s.grey ? '0 : h;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= pix_valid;
            end
            for (int i = 1; i <= LAST; i++)
            begin
                if (adv[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0] && pix_valid)
        begin
            stg_reg[0] <= stg_next[0];
        end
        for (int i = 1; i <= NUM_DIV_STG; i++)
        begin
            if (adv[i] && v_reg[i-1])
            begin
                stg_reg[i] <= stg_next[i];
            end
        end
        if (adv[LAST] && v_reg[LAST-1])
        begin
            hue_reg <= hue_next;
            sat_reg <= stg_reg[NUM_DIV_STG].grey ? '0 : stg_reg[NUM_DIV_STG].sat.quo;
            val_reg <= stg_reg[NUM_DIV_STG].val;
        end
    end

    assign hsv_valid  = v_reg[LAST];
    assign hue_deg    = hue_reg;
    assign sat_scaled = sat_reg;
    assign val_out    = val_reg;

    // saturation is at least one whenever the pixel is not grey
    a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
        (hsv_valid && sat_scaled == '0) |-> (hue_deg == '0))
        else $error("nonzero hue with zero saturation");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid |-> (hue_deg <= HUE_MAX))
        else $error("hue out of range");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !hsv_valid |-> pix_ready)
        else $error("input stalled with empty output stage");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (hsv_valid && val_out == '0) |-> (sat_scaled == '0 && hue_deg == '0))
        else $error("black pixel with nonzero hue or saturation");

endmodule

// File: tb/sv/rgb_to_hsv_pixel_core_tb.sv
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_core_tb;

    import rgbhsv_pkg::*;

    typedef struct {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  val;
    } hsv_t;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             pix_valid  = 1'b0;
    logic             pix_ready;
    logic [CH_W-1:0]  red_in     = '0;
    logic [CH_W-1:0]  green_in   = '0;
    logic [CH_W-1:0]  blue_in    = '0;
    logic             hsv_valid;
    logic             hsv_ready  = 1'b0;
    logic [HUE_W-1:0] hue_deg;
    logic [CH_W-1:0]  sat_scaled;
    logic [CH_W-1:0]  val_out;

    hsv_t expected_hsv[$];
    int   mismatch_count = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   hold_cycles    = 0;

    rgb_to_hsv_pixel_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .hsv_valid  (hsv_valid),
        .hsv_ready  (hsv_ready),
        .hue_deg    (hue_deg),
        .sat_scaled (sat_scaled),
        .val_out    (val_out)
    );

    always #2 clk = ~clk;

    function automatic hsv_t hsv_of_pixel(input logic [CH_W-1:0] r8, g8, b8);
        hsv_t        res;
        int unsigned r, g, b, hi, lo, delta, num, hue;
        sector_t     sect;
        r = r8;
        g = g8;
        b = b8;
        hi = (r > g) ? r : g;
        hi = (hi > b) ? hi : b;
        lo = (r < g) ? r : g;
        lo = (lo < b) ? lo : b;
        delta = hi - lo;
        res.val = CH_W'(hi);
        res.hue = '0;
        res.sat = '0;
        if (delta != 0)
        begin
            res.sat = CH_W'((255 * delta) / hi);
            if (r >= hi)
                sect = SECT_RED;
            else if (g >= hi)
                sect = SECT_GREEN;
            else
                sect = SECT_BLUE;
            case (sect)
                SECT_RED:
                    num = (g >= b) ? 60 * (g - b)
                                   : HUE_WRAP * delta - 60 * (b - g);
                SECT_GREEN:
                    num = (b >= r) ? HUE_GREEN_OFF * delta + 60 * (b - r)
                                   : HUE_GREEN_OFF * delta - 60 * (r - b);
                default:
                    num = (r >= g) ? HUE_BLUE_OFF * delta + 60 * (r - g)
                                   : HUE_BLUE_OFF * delta - 60 * (g - r);
            endcase
            hue = num / delta;
            if (hue > HUE_MAX)
                hue = HUE_MAX;
            res.hue = HUE_W'(hue);
        end
        return res;
    endfunction

    // receiver: long hold-off first, then random stalls
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles = hold_cycles - 1;
            hsv_ready <= 1'b0;
        end
        else
        begin
            hsv_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        hsv_t want;
        if (rst_n && hsv_valid && hsv_ready)
        begin
            if (expected_hsv.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected result: hue %0d sat %0d val %0d",
                             hue_deg, sat_scaled, val_out);
                mismatch_count++;
            end
            else
            begin
                want = expected_hsv.pop_front();
                if (hue_deg !== want.hue || sat_scaled !== want.sat ||
                    val_out !== want.val)
                begin
                    if (mismatch_count < 10)
                        $display("mismatch (hue sat val): expected %0d %0d %0d, got %0d %0d %0d",
                                 want.hue, want.sat, want.val,
                                 hue_deg, sat_scaled, val_out);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_pixel(input logic [CH_W-1:0] r, g, b);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        red_in    <= r;
        green_in  <= g;
        blue_in   <= b;
        @(posedge clk);
        while (!pix_ready)
            @(posedge clk);
        expected_hsv.push_back(hsv_of_pixel(r, g, b));
    endtask

    task automatic random_pixel(output logic [CH_W-1:0] r, g, b);
        r = CH_W'($urandom_range(255));
        g = CH_W'($urandom_range(255));
        b = CH_W'($urandom_range(255));
        case ($urandom_range(9))
            0:
            begin
                g = r;
                b = r;
            end
            1: g = r;
            2: b = g;
            3: b = r;
            4:
            begin
                r = CH_W'($urandom_range(3));
                g = CH_W'($urandom_range(3));
                b = CH_W'($urandom_range(3));
            end
            5:
            begin
                r = CH_W'(255 - $urandom_range(2));
                g = CH_W'($urandom_range(2));
            end
            default: ;
        endcase
    endtask

    task automatic send_random(input int count);
        logic [CH_W-1:0] r, g, b;
        repeat (count)
        begin
            random_pixel(r, g, b);
            send_pixel(r, g, b);
        end
    endtask

    task automatic wait_for_results();
        pix_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_hsv.size() != 0);
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // grey, including black and white
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        // primaries and secondaries
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        // ties for the largest channel
        send_pixel(8'd200, 8'd200, 8'd50);
        send_pixel(8'd50,  8'd200, 8'd200);
        send_pixel(8'd200, 8'd50,  8'd200);
        // red largest with blue above green, then green above blue, mostly near the wrap
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd255, 8'd0,   8'd254);
        send_pixel(8'd255, 8'd1,   8'd0);
        // smallest nonzero deltas
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd1,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd255, 8'd254, 8'd254);
        // each sub-case of the green and blue sectors, then one red-sector pixel
        send_pixel(8'd10,  8'd200, 8'd30);
        send_pixel(8'd30,  8'd200, 8'd10);
        send_pixel(8'd30,  8'd10,  8'd200);
        send_pixel(8'd10,  8'd30,  8'd200);
        send_pixel(8'd170, 8'd85,  8'd0);
    endtask

    task automatic test_random_phase(input int count, input int idle_pct,
                                     input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        send_random(count);
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 300;
        send_random(50);
    endtask

    task automatic test_drain_pause();
        send_idle_pct  = 18;
        recv_stall_pct = 18;
        send_random(30);
        wait_for_results();
        send_random(30);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phase(375, 0, 0);
        test_random_phase(375, 65, 0);
        test_random_phase(375, 0, 65);
        test_random_phase(375, 18, 18);
        test_backpressure();
        test_drain_pause();
        wait_for_results();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_hsv.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
